>>> hw/rtl/pcwc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcwc_pkg
// Shared types and constants of the fixed-point pid controller with
// integral clamp: beat payloads, register indexes, controller commands.
// ----------------------------------------------------------------------------
package pcwc_pkg;

  localparam int DATA_WIDTH        = 32;
  localparam int FRAC_BITS         = 16;
  localparam int DT_WIDTH          = 31;
  localparam int CFG_IDX_WIDTH     = 2;
  localparam int INTEG_LIMIT_UNITS = 50;

  // operand width of the shared multiplier: signed word or zero-extended dt
  localparam int MUL_WIDTH  = DATA_WIDTH + 1;
  localparam int PROD_WIDTH = 2 * MUL_WIDTH;
  // accumulator holds the sum of three saturated words
  localparam int ACC_WIDTH  = DATA_WIDTH + 2;
  // high part of the divider numerator |diff| << FRAC_BITS above DATA_WIDTH bits
  localparam int NUM_HI_WIDTH = MUL_WIDTH - (DATA_WIDTH - FRAC_BITS);

  localparam logic [DATA_WIDTH-1:0] WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic signed [DATA_WIDTH-1:0] INTEG_LIMIT =
    DATA_WIDTH'(INTEG_LIMIT_UNITS * (2 ** FRAC_BITS));

  localparam logic [CFG_IDX_WIDTH-1:0] REG_GAIN_P = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_GAIN_I = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_GAIN_D = 2'd2;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] target_value;
    logic signed [DATA_WIDTH-1:0] measured_value;
    logic        [DT_WIDTH-1:0]   time_step;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] drive_value;
    logic                         output_saturated;
    logic                         step_zero;
  } out_item_t;

  typedef enum logic [1:0] {
    MUL_INC = 2'd0,
    MUL_P   = 2'd1,
    MUL_I   = 2'd2,
    MUL_D   = 2'd3
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     calc_err;
    logic     div_start;
    mul_sel_t mul_sel;
    logic     integ_upd;
    logic     acc_load;
    logic     acc_add;
    logic     deriv_load;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

>>> hw/rtl/pcwc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcwc_div
// Restoring divider, one quotient bit per cycle, for the derivative term
// (|diff| << FRAC_BITS) / dt with an up-front overflow check.
// ----------------------------------------------------------------------------
module pcwc_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [pcwc_pkg::NUM_HI_WIDTH-1:0] num_hi,
  input  logic [pcwc_pkg::DATA_WIDTH-1:0]   num_lo,
  input  logic [pcwc_pkg::DT_WIDTH-1:0]     den,
  output logic                              busy,
  output logic                              ovf,
  output logic [pcwc_pkg::DATA_WIDTH-1:0]   quo
);
  import pcwc_pkg::*;

  localparam int CNT_WIDTH = $clog2(DATA_WIDTH);

  logic                  busy_r;
  logic                  ovf_r;
  logic [CNT_WIDTH-1:0]  cnt_r;
  logic [DT_WIDTH-1:0]   rem_r;
  logic [DATA_WIDTH-1:0] quo_r;
  logic [DT_WIDTH:0]     trial;
  logic                  ge;

  // numerator bits shift out of the top of quo_r, quotient bits shift in below
  assign trial = {rem_r, quo_r[DATA_WIDTH-1]};
  assign ge    = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_WIDTH'(DATA_WIDTH - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // quotient would need more than DATA_WIDTH bits
      ovf_r <= ({{(DT_WIDTH-NUM_HI_WIDTH){1'b0}}, num_hi} >= den);
      rem_r <= DT_WIDTH'(num_hi);
      quo_r <= num_lo;
    end else if (busy_r) begin
      rem_r <= ge ? DT_WIDTH'(trial - {1'b0, den}) : trial[DT_WIDTH-1:0];
      quo_r <= {quo_r[DATA_WIDTH-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign ovf  = ovf_r;
  assign quo  = quo_r;

endmodule

>>> hw/rtl/pcwc_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcwc_dpath
// Datapath: gain registers, error and integral state, shared multiplier,
// derivative divider, accumulator and the output register.
// ----------------------------------------------------------------------------
module pcwc_dpath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [pcwc_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [pcwc_pkg::DATA_WIDTH-1:0]    cfg_data,
  input  pcwc_pkg::in_item_t                 in_data,
  input  pcwc_pkg::ctrl_cmd_t                cmd,
  output pcwc_pkg::dp_status_t               status,
  output logic                               out_valid,
  input  logic                               out_stall,
  output pcwc_pkg::out_item_t                out_data
);
  import pcwc_pkg::*;

  localparam int MTOP_WIDTH = PROD_WIDTH - FRAC_BITS - DATA_WIDTH + 1;
  localparam int STOP_WIDTH = ACC_WIDTH - DATA_WIDTH + 1;
  localparam logic signed [ACC_WIDTH-1:0] LIM_HI = ACC_WIDTH'(INTEG_LIMIT);
  localparam logic signed [ACC_WIDTH-1:0] LIM_LO = -LIM_HI;

  // {sat, value}: clip a wide sum to one word
  function automatic logic [DATA_WIDTH:0] sat_word(input logic [ACC_WIDTH-1:0] v);
    logic [STOP_WIDTH-1:0] top;
    top = v[ACC_WIDTH-1:DATA_WIDTH-1];
    if ((&top) || !(|top)) begin
      return {1'b0, v[DATA_WIDTH-1:0]};
    end
    return {1'b1, v[ACC_WIDTH-1] ? WORD_MIN : WORD_MAX};
  endfunction

  // {sat, value}: floor(p / 2^FRAC_BITS), clipped to one word
  function automatic logic [DATA_WIDTH:0] mul_round(input logic [PROD_WIDTH-1:0] p);
    logic [MTOP_WIDTH-1:0] top;
    top = p[PROD_WIDTH-1:FRAC_BITS+DATA_WIDTH-1];
    if ((&top) || !(|top)) begin
      return {1'b0, p[FRAC_BITS+DATA_WIDTH-1:FRAC_BITS]};
    end
    return {1'b1, p[PROD_WIDTH-1] ? WORD_MIN : WORD_MAX};
  endfunction

  logic signed [DATA_WIDTH-1:0] gain_p_r, gain_i_r, gain_d_r;
  logic signed [DATA_WIDTH-1:0] target_r, measured_r;
  logic        [DT_WIDTH-1:0]   dt_r;
  logic signed [DATA_WIDTH-1:0] err_r, prev_err_r, integ_r, deriv_r;
  logic                         diff_neg_r, zero_r, sat_r;
  logic signed [PROD_WIDTH-1:0] prod_r;
  logic signed [ACC_WIDTH-1:0]  acc_r;
  logic                         out_valid_r;
  out_item_t                    out_data_r;

  logic signed [MUL_WIDTH-1:0]  mul_a, mul_b;
  logic signed [PROD_WIDTH-1:0] mul_p;
  logic [DATA_WIDTH:0]          err_w, prod_w, sum_w;
  logic signed [MUL_WIDTH-1:0]  diff;
  logic [MUL_WIDTH-1:0]         diff_mag;
  logic signed [ACC_WIDTH-1:0]  integ_sum, prod_ext;
  logic                         div_busy, div_ovf, d_over;
  logic [DATA_WIDTH-1:0]        div_quo, deriv_val;

  // ---- configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= '0;
      gain_i_r <= '0;
      gain_d_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_P: gain_p_r <= cfg_data;
        REG_GAIN_I: gain_i_r <= cfg_data;
        REG_GAIN_D: gain_d_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- shared multiplier, product registered
  always_comb begin
    case (cmd.mul_sel)
      MUL_INC: begin
        mul_a = {err_r[DATA_WIDTH-1], err_r};
        mul_b = {{(MUL_WIDTH-DT_WIDTH){1'b0}}, dt_r};
      end
      MUL_P: begin
        mul_a = {gain_p_r[DATA_WIDTH-1], gain_p_r};
        mul_b = {err_r[DATA_WIDTH-1], err_r};
      end
      MUL_I: begin
        mul_a = {gain_i_r[DATA_WIDTH-1], gain_i_r};
        mul_b = {integ_r[DATA_WIDTH-1], integ_r};
      end
      MUL_D: begin
        mul_a = {gain_d_r[DATA_WIDTH-1], gain_d_r};
        mul_b = {deriv_r[DATA_WIDTH-1], deriv_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod_r <= mul_p;
  end

  assign prod_w   = mul_round(prod_r);
  assign prod_ext = {{(ACC_WIDTH-DATA_WIDTH){prod_w[DATA_WIDTH-1]}},
                     prod_w[DATA_WIDTH-1:0]};

  // ---- error and difference to the previous error
  assign err_w = sat_word({{(ACC_WIDTH-DATA_WIDTH){target_r[DATA_WIDTH-1]}}, target_r}
                        - {{(ACC_WIDTH-DATA_WIDTH){measured_r[DATA_WIDTH-1]}}, measured_r});
  assign diff     = {err_r[DATA_WIDTH-1], err_r} - {prev_err_r[DATA_WIDTH-1], prev_err_r};
  assign diff_mag = diff[MUL_WIDTH-1] ? MUL_WIDTH'(-diff) : MUL_WIDTH'(diff);

  // ---- integral update with clamp
  assign integ_sum = {{(ACC_WIDTH-DATA_WIDTH){integ_r[DATA_WIDTH-1]}}, integ_r} + prod_ext;

  // ---- derivative divider
  pcwc_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.div_start),
    .num_hi (diff_mag[MUL_WIDTH-1:DATA_WIDTH-FRAC_BITS]),
    .num_lo ({diff_mag[DATA_WIDTH-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}}),
    .den    (dt_r),
    .busy   (div_busy),
    .ovf    (div_ovf),
    .quo    (div_quo)
  );

  // a negative quotient may reach the magnitude of the most negative word
  assign d_over = div_ovf || (diff_neg_r ? (div_quo[DATA_WIDTH-1] && (|div_quo[DATA_WIDTH-2:0]))
                                         : div_quo[DATA_WIDTH-1]);

  always_comb begin
    if (zero_r) begin
      deriv_val = '0;
    end else if (d_over) begin
      deriv_val = diff_neg_r ? WORD_MIN : WORD_MAX;
    end else begin
      deriv_val = diff_neg_r ? -div_quo : div_quo;
    end
  end

  assign sum_w = sat_word(acc_r);

  // ---- state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r    <= '0;
      prev_err_r <= '0;
    end else begin
      if (cmd.div_start) begin
        prev_err_r <= err_r;
      end
      if (cmd.integ_upd) begin
        if (integ_sum > LIM_HI) begin
          integ_r <= INTEG_LIMIT;
        end else if (integ_sum < LIM_LO) begin
          integ_r <= -INTEG_LIMIT;
        end else begin
          integ_r <= integ_sum[DATA_WIDTH-1:0];
        end
      end
    end
  end

  // ---- working registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      target_r   <= in_data.target_value;
      measured_r <= in_data.measured_value;
      dt_r       <= in_data.time_step;
    end
    if (cmd.calc_err) begin
      err_r  <= err_w[DATA_WIDTH-1:0];
      sat_r  <= err_w[DATA_WIDTH];
      zero_r <= (dt_r == '0);
    end else if (cmd.acc_load || cmd.acc_add) begin
      sat_r <= sat_r | prod_w[DATA_WIDTH];
    end else if (cmd.deriv_load) begin
      sat_r <= sat_r | (d_over && !zero_r);
    end
    if (cmd.div_start) begin
      diff_neg_r <= diff[MUL_WIDTH-1];
    end
    if (cmd.acc_load) begin
      acc_r <= prod_ext;
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + prod_ext;
    end
    if (cmd.deriv_load) begin
      deriv_r <= deriv_val;
    end
  end

  // ---- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.drive_value      <= sum_w[DATA_WIDTH-1:0];
      out_data_r.output_saturated <= sat_r | sum_w[DATA_WIDTH];
      out_data_r.step_zero        <= zero_r;
    end
  end

  assign status.div_done = !div_busy;
  assign status.out_free = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;

endmodule

>>> hw/rtl/pcwc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcwc_ctrl
// Sequencer for one control step: error, integral, gain products, then the
// derivative once the divider finishes, then the output load.
// ----------------------------------------------------------------------------
module pcwc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pcwc_pkg::dp_status_t  status,
  output pcwc_pkg::ctrl_cmd_t   cmd
);
  import pcwc_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_ERR   = 10'b0000000010,
    ST_DINIT = 10'b0000000100,
    ST_INTEG = 10'b0000001000,
    ST_PTERM = 10'b0000010000,
    ST_ITERM = 10'b0000100000,
    ST_DWAIT = 10'b0001000000,
    ST_DMUL  = 10'b0010000000,
    ST_DTERM = 10'b0100000000,
    ST_EMIT  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mul_sel = MUL_INC;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_ERR;
        end
      end
      ST_ERR: begin
        cmd.calc_err = 1'b1;
        state_nxt    = ST_DINIT;
      end
      ST_DINIT: begin
        // divider runs in the background from here on
        cmd.div_start = 1'b1;
        cmd.mul_sel   = MUL_INC;
        state_nxt     = ST_INTEG;
      end
      ST_INTEG: begin
        cmd.integ_upd = 1'b1;
        cmd.mul_sel   = MUL_P;
        state_nxt     = ST_PTERM;
      end
      ST_PTERM: begin
        cmd.acc_load = 1'b1;
        cmd.mul_sel  = MUL_I;
        state_nxt    = ST_ITERM;
      end
      ST_ITERM: begin
        cmd.acc_add = 1'b1;
        state_nxt   = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (status.div_done) begin
          cmd.deriv_load = 1'b1;
          state_nxt      = ST_DMUL;
        end
      end
      ST_DMUL: begin
        cmd.mul_sel = MUL_D;
        state_nxt   = ST_DTERM;
      end
      ST_DTERM: begin
        cmd.acc_add = 1'b1;
        state_nxt   = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/pid_controller_windup_clamp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_windup_clamp
// Fixed-point Q16.16 pid controller with the integral clamped to +/-50.0.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per control step (set point, measurement, time step).
//           in_stall is low only while the block is idle; a beat is taken at
//           a rising edge with in_valid high and in_stall low.
//   out_* : one beat per input beat (drive value, saturation and zero-step
//           flags), held in an output register until taken (out_stall low).
//   cfg_* : gain writes, always ready; index 0 = Kp, 1 = Ki, 2 = Kd, other
//           indexes are ignored. Write only while no step is in flight.
// Flow: a step runs from the input beat to out_valid; the one-bit-per-cycle
//   divider for the derivative sets its length. A new input beat is taken
//   only once the controller is back in idle after the output register
//   loads, so steps do not overlap.
// Stalling: while out_stall holds the previous result, the block still takes
//   and computes the next step and waits only before loading its result.
// Reset: clears the gains, the integral and the previous error; no result
//   is pending after reset.
// ----------------------------------------------------------------------------
module pid_controller_windup_clamp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  pcwc_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output pcwc_pkg::out_item_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pcwc_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [pcwc_pkg::DATA_WIDTH-1:0]    cfg_data
);
  import pcwc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  pcwc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  pcwc_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // one step in flight: the beat after an accepted one is held off
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a step is in flight");

  a_div_idle_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> status.div_done)
    else $error("divider restarted while busy");

  a_deriv_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.deriv_load |-> status.div_done)
    else $error("derivative loaded before the divider finished");

  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> status.out_free)
    else $error("result loaded over an untaken beat");

  a_out_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("loaded result not presented");

endmodule

>>> tb/tb_pid_controller_windup_clamp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pid_controller_windup_clamp
// Self-checking bench for the Q16.16 pid controller with integral clamp.
// A directed list of steps and gain writes runs first. Random phases follow,
// each with its own gain setting. Every input beat is run through a local
// model of the controller, and each output beat is compared field by field
// with the oldest queued expected beat. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_pid_controller_windup_clamp;
  import pcwc_pkg::*;

  localparam int RAND_PHASES     = 6;
  localparam int STEPS_PER_PHASE = 215;
  localparam int PRESSURE_AT     = 300;
  localparam int PRESSURE_HOLD   = 400;
  localparam int SETTLE_CYCLES   = 4;
  localparam int TAIL_CYCLES     = 60;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_NONE = 2'd3;

  localparam logic [DATA_WIDTH-1:0] Q_ONE     = 32'h0001_0000;
  localparam logic [DATA_WIDTH-1:0] Q_NEG_ONE = 32'hFFFF_0000;

  localparam longint W_MAX     = 64'sd2147483647;
  localparam longint W_MIN     = -W_MAX - 1;
  localparam longint INTEG_MAX = longint'(INTEG_LIMIT_UNITS) << FRAC_BITS;

  typedef enum bit {ROW_STEP, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic [CFG_IDX_WIDTH-1:0]   idx;
    logic [DATA_WIDTH-1:0]      val;
    in_item_t                   item;
    bit                         typed;
    out_item_t                  exp;
  } row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  in_item_t                 in_data = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  out_item_t                out_data;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
  logic [DATA_WIDTH-1:0]    cfg_data = '0;

  // controller model state
  longint gain_p, gain_i, gain_d;
  longint integ_acc, last_err;

  out_item_t pending_drive[$];
  row_t      plan[$];
  int        results_seen = 0;
  int        fail_count = 0;
  bit        quiet = 1'b0;

  pid_controller_windup_clamp u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic longint sat_word(longint v, inout bit sat);
    if (v > W_MAX) begin
      sat = 1'b1;
      return W_MAX;
    end
    if (v < W_MIN) begin
      sat = 1'b1;
      return W_MIN;
    end
    return v;
  endfunction

  // floor(a*b / 2^FRAC_BITS), operands small enough that the product fits 63 bits
  function automatic longint q_mul(longint a, longint b, inout bit sat);
    return sat_word((a * b) >>> FRAC_BITS, sat);
  endfunction

  // diff / dt in Q format, truncated toward zero
  function automatic longint q_div(longint diff, longint dt, inout bit sat);
    longint mag_d, lim, q;
    mag_d = (diff < 0) ? -diff : diff;
    lim   = (diff < 0) ? -W_MIN : W_MAX;
    q     = (mag_d << FRAC_BITS) / dt;
    if (q > lim) begin
      sat = 1'b1;
      q = lim;
    end
    return (diff < 0) ? -q : q;
  endfunction

  function automatic out_item_t pid_predict(in_item_t it);
    out_item_t r;
    bit        sat, dropped;
    longint    err, dt, deriv, p, i, d;
    sat     = 1'b0;
    dropped = 1'b0;
    dt  = longint'({1'b0, it.time_step});
    err = sat_word(longint'($signed(it.target_value)) -
                   longint'($signed(it.measured_value)), sat);
    // clipping of the integral step never reaches the flag
    integ_acc = integ_acc + q_mul(err, dt, dropped);
    if (integ_acc > INTEG_MAX) integ_acc = INTEG_MAX;
    if (integ_acc < -INTEG_MAX) integ_acc = -INTEG_MAX;
    deriv = (dt == 0) ? 0 : q_div(err - last_err, dt, sat);
    last_err = err;
    p = q_mul(gain_p, err, sat);
    i = q_mul(gain_i, integ_acc, sat);
    d = q_mul(gain_d, deriv, sat);
    r.drive_value      = 32'(sat_word(p + i + d, sat));
    r.output_saturated = sat;
    r.step_zero        = (dt == 0);
    return r;
  endfunction

  function automatic row_t cfg_row(logic [CFG_IDX_WIDTH-1:0] idx, logic [DATA_WIDTH-1:0] val);
    row_t w;
    w      = '0;
    w.kind = ROW_CFG;
    w.idx  = idx;
    w.val  = val;
    return w;
  endfunction

  function automatic row_t step_row(logic [DATA_WIDTH-1:0] t, logic [DATA_WIDTH-1:0] m,
                                    logic [DT_WIDTH-1:0] dt);
    row_t w;
    w                     = '0;
    w.kind                = ROW_STEP;
    w.item.target_value   = t;
    w.item.measured_value = m;
    w.item.time_step      = dt;
    return w;
  endfunction

  function automatic row_t typed_row(logic [DATA_WIDTH-1:0] t, logic [DATA_WIDTH-1:0] m,
                                     logic [DT_WIDTH-1:0] dt, logic [DATA_WIDTH-1:0] drv,
                                     bit sat, bit zero);
    row_t w;
    w       = step_row(t, m, dt);
    w.typed = 1'b1;
    w.exp   = '{drv, sat, zero};
    return w;
  endfunction

  function automatic logic [DATA_WIDTH-1:0] pick_gain();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2:       return '0;
      7, 8:    return 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
      9:       return $urandom;
      default: return 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
    endcase
  endfunction

  function automatic logic [DATA_WIDTH-1:0] pick_extreme();
    case ($urandom_range(0, 3))
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2:       return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t pick_step();
    in_item_t it;
    int       r;
    r = $urandom_range(0, 99);
    // plant near set point: targets within +/-100.0, measured +/-4.0 off, dt up to 1.0
    it.target_value   = 32'($urandom_range(0, 32'h00C8_0000)) - 32'h0064_0000;
    it.measured_value = it.target_value + 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
    it.time_step      = 31'($urandom_range(32'h40, 32'h0001_0000));
    if (r >= 60 && r < 75) begin
      it.target_value   = $urandom;
      it.measured_value = $urandom;
      it.time_step      = 31'($urandom);
    end else if (r >= 75 && r < 85) begin
      case ($urandom_range(0, 2))
        0:       it.time_step = '0;
        1:       it.time_step = 31'd1;
        default: it.time_step = '1;
      endcase
    end else if (r >= 85) begin
      it.target_value   = pick_extreme();
      it.measured_value = pick_extreme();
    end
    return it;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // hold input off until every predicted drive value has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [DATA_WIDTH-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_GAIN_P: gain_p = longint'($signed(val));
      REG_GAIN_I: gain_i = longint'($signed(val));
      REG_GAIN_D: gain_d = longint'($signed(val));
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_step(in_item_t it, bit typed, out_item_t typed_exp);
    out_item_t guess;
    int        gap;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    guess = pid_predict(it);
    pending_drive.push_back(typed ? typed_exp : guess);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (pending_drive.size() == 0) begin
        $error("unexpected result beat: drive_value %0d", $signed(out_data.drive_value));
        fail_count++;
      end else begin
        want = pending_drive.pop_front();
        if (out_data.drive_value !== want.drive_value) begin
          $error("drive_value mismatch: expected %0d, actual %0d",
                 $signed(want.drive_value), $signed(out_data.drive_value));
          fail_count++;
        end
        if (out_data.output_saturated !== want.output_saturated) begin
          $error("output_saturated mismatch: expected %0b, actual %0b",
                 want.output_saturated, out_data.output_saturated);
          fail_count++;
        end
        if (out_data.step_zero !== want.step_zero) begin
          $error("step_zero mismatch: expected %0b, actual %0b",
                 want.step_zero, out_data.step_zero);
          fail_count++;
        end
      end
    end
  end

  initial begin : receiver
    int r;
    bit pressed;
    pressed = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (!pressed && results_seen >= PRESSURE_AT) begin
        // long hold-off while the sender keeps offering beats
        pressed = 1'b1;
        out_stall <= 1'b1;
        repeat (PRESSURE_HOLD) @(posedge clk);
      end else if (quiet || r < 70) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (r < 95) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(10, 60)) @(posedge clk);
      end
    end
  end

  initial begin
    #(64'd10_000_000);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    gain_p    = 0;
    gain_i    = 0;
    gain_d    = 0;
    integ_acc = 0;
    last_err  = 0;

    plan = '{
      // gains are zero out of reset, so only the flags can be nonzero
      typed_row(32'h0, 32'h0, 31'h0, 32'h0, 1'b0, 1'b1),
      typed_row(WORD_MAX, WORD_MIN, 31'(Q_ONE), 32'h0, 1'b1, 1'b0),
      typed_row(WORD_MIN, WORD_MAX, 31'h0, 32'h0, 1'b1, 1'b1),
      // error jumps from the minimum to zero over the smallest dt: derivative clips
      typed_row(32'h0, 32'h0, 31'h1, 32'h0, 1'b1, 1'b0),
      typed_row(32'h0, 32'h0, 31'h7FFF_FFFF, 32'h0, 1'b0, 1'b0),
      cfg_row(REG_GAIN_P, Q_ONE),
      cfg_row(REG_GAIN_I, Q_ONE),
      cfg_row(REG_GAIN_D, 32'h0),
      step_row(Q_ONE, 32'h0, 31'(Q_ONE)),
      step_row(WORD_MAX, 32'h0, 31'h7FFF_FFFF),
      step_row(WORD_MIN, 32'h0, 31'h7FFF_FFFF),
      step_row(32'hFFFF_FFFF, 32'h0, 31'h3),
      cfg_row(REG_GAIN_P, WORD_MAX),
      cfg_row(REG_GAIN_I, WORD_MIN),
      cfg_row(REG_GAIN_D, WORD_MAX),
      step_row(32'h1, 32'h0, 31'(Q_ONE)),
      step_row(32'h0, 32'h0003_0000, 31'h0000_8000),
      step_row(32'h7FFF_0000, 32'h8001_0000, 31'h1),
      step_row(32'h0, 32'h0, 31'h0),
      cfg_row(REG_NONE, 32'hA5A5_5A5A),
      cfg_row(REG_GAIN_P, WORD_MIN),
      cfg_row(REG_GAIN_D, Q_ONE),
      step_row(32'h0005_0000, 32'h0, 31'h100),
      step_row(32'hFFFB_0000, 32'h0, 31'h100),
      step_row(32'h1, 32'h0, 31'h7FFF_FFFF),
      step_row(WORD_MIN, WORD_MIN, 31'(Q_ONE)),
      cfg_row(REG_GAIN_I, Q_NEG_ONE),
      step_row(32'h0064_0000, 32'h0, 31'(Q_ONE)),
      step_row(32'hFF9C_0000, 32'h0, 31'(Q_ONE))
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_CFG) begin
        drain();
        write_reg(plan[k].idx, plan[k].val);
      end else begin
        send_step(plan[k].item, plan[k].typed, plan[k].exp);
      end
    end

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      drain();
      quiet = (phase == 2);
      write_reg(REG_GAIN_P, pick_gain());
      write_reg(REG_GAIN_I, pick_gain());
      write_reg(REG_GAIN_D, pick_gain());
      if ($urandom_range(0, 2) == 0) write_reg(REG_NONE, $urandom);
      for (int n = 0; n < STEPS_PER_PHASE; n++) begin
        send_step(pick_step(), 1'b0, '0);
        if ($urandom_range(0, 149) == 0) drain();
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
